// ===== rtl/ste_pkg.sv =====
// Shared types, codes and a helper function for the symbol table engine.
// No dependencies; ste_ctrl and symbol_table_engine import this package.
package ste_pkg;

    localparam int LABEL_BYTES = 20;
    localparam int LABEL_W     = 8 * LABEL_BYTES;
    localparam int IN_DATA_W   = 176;
    localparam int OUT_DATA_W  = 184;
    localparam int INDEX_W     = 6;
    localparam int ADDR_OUT_W  = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_MODIFY = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_MODIFIED  = 3'd5,
        ST_ENTRY     = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef struct packed {
        logic                  last;
        logic [ADDR_OUT_W-1:0] address;
        logic [LABEL_W-1:0]    label;
        logic [INDEX_W-1:0]    index;
        status_t               status;
    } result_t;

    // Clears every byte after the first zero byte, so labels compare like strings.
    function automatic logic [LABEL_W-1:0] normalize_label(input logic [LABEL_W-1:0] raw);
        logic [LABEL_W-1:0] cleaned;
        logic               ended;
        cleaned = raw;
        ended   = 1'b0;
        for (int i = 0; i < LABEL_BYTES; i++)
        begin
            if (ended)
            begin
                cleaned[8*i +: 8] = 8'h00;
            end
            else if (raw[8*i +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
        return cleaned;
    endfunction

endpackage

// ===== rtl/ste_store.sv =====
// Entry memory of the symbol table engine: label and address per entry.
// One write port and one registered read port; depends on nothing else.
module ste_store #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6,
    parameter int DATA_W = 176
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] entry_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // The read register holds its value while no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ste_ctrl.sv =====
// Sequencer of the symbol table engine: scans the entry memory, decides each
// request and produces its results. Depends on ste_pkg and drives ste_store.
module ste_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 16,
    parameter int CNT_W       = 7,
    parameter int IDX_W       = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ste_pkg::op_t                         in_op,
    input  logic [ste_pkg::IN_DATA_W-1:0]        in_data,
    input  logic                                 out_free,
    output logic                                 res_load,
    output ste_pkg::result_t                     res,
    output logic                                 mem_rd_en,
    output logic [IDX_W-1:0]                     mem_rd_idx,
    input  logic [ste_pkg::LABEL_W+ADDR_BITS-1:0] mem_rd_data,
    output logic                                 mem_wr_en,
    output logic [IDX_W-1:0]                     mem_wr_idx,
    output logic [ste_pkg::LABEL_W+ADDR_BITS-1:0] mem_wr_data
);
    import ste_pkg::*;

    localparam int DUMP_MAX = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DUMP = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   pend_reg, pend_next;
    logic                   hit_reg, hit_next;
    op_t                    op_reg, op_next;
    logic [LABEL_W-1:0]     label_reg, label_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;

    logic [LABEL_W-1:0]     rd_label;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   match;
    logic                   hit;
    logic                   issue;
    logic                   dump_load;
    logic [CNT_W-1:0]       dump_lim;

    function automatic logic [ADDR_BITS-1:0] to_store_addr(input logic [ADDR_OUT_W-1:0] a);
        logic [ADDR_BITS+ADDR_OUT_W-1:0] ext;
        ext = {{ADDR_BITS{1'b0}}, a};
        return ext[ADDR_BITS-1:0];
    endfunction

    function automatic logic [ADDR_OUT_W-1:0] to_out_addr(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS+ADDR_OUT_W-1:0] ext;
        ext = {{ADDR_OUT_W{1'b0}}, a};
        return ext[ADDR_OUT_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] i);
        logic [CNT_W+INDEX_W-1:0] ext;
        ext = {{INDEX_W{1'b0}}, i};
        return ext[INDEX_W-1:0];
    endfunction

    assign rd_label = mem_rd_data[LABEL_W-1:0];
    assign rd_addr  = mem_rd_data[LABEL_W +: ADDR_BITS];
    assign match    = (rd_label == label_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign dump_lim = (count_reg > CNT_W'(DUMP_MAX)) ? CNT_W'(DUMP_MAX) : count_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        op_next      = op_reg;
        label_next   = label_reg;
        addr_next    = addr_reg;
        hit          = 1'b0;
        issue        = 1'b0;
        dump_load    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_idx   = rd_idx_reg[IDX_W-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_idx   = cmp_idx_reg[IDX_W-1:0];
        mem_wr_data  = {addr_reg, label_reg};
        res_load     = 1'b0;
        res          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_op;
                    label_next  = normalize_label(in_data[LABEL_W-1:0]);
                    addr_next   = to_store_addr(in_data[LABEL_W +: ADDR_OUT_W]);
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else if (in_op == OP_DUMP)
                    begin
                        state_next = S_DUMP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // One entry is read per cycle; the compare works on the previous read.
                hit   = pend_reg && match;
                issue = !hit && (rd_idx_reg < count_reg);
                if (issue)
                begin
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_idx_next = rd_idx_reg;
                end
                pend_next = issue;
                if (hit)
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESP;
                end
                else if (rd_idx_reg == count_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_RESP;
                end
            end

            S_DUMP:
            begin
                // A new read is issued only when the previous entry has been sent,
                // so the read register holds the entry across an output stall.
                dump_load = pend_reg && out_free;
                issue     = (!pend_reg || dump_load) && (rd_idx_reg < dump_lim);
                if (issue)
                begin
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_idx_next = rd_idx_reg;
                    pend_next    = 1'b1;
                end
                else if (dump_load)
                begin
                    pend_next = 1'b0;
                end
                if (dump_load)
                begin
                    res_load    = 1'b1;
                    res.status  = ST_ENTRY;
                    res.index   = to_index(cmp_idx_reg);
                    res.label   = rd_label;
                    res.address = to_out_addr(rd_addr);
                    res.last    = (rd_idx_reg == dump_lim);
                    if (rd_idx_reg == dump_lim)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                res.status  = ST_DUPLICATE;
                                res.index   = to_index(cmp_idx_reg);
                                res.label   = rd_label;
                                res.address = to_out_addr(rd_addr);
                            end
                            else if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_idx  = count_reg[IDX_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                                res.status  = ST_INSERTED;
                                res.index   = to_index(count_reg);
                                res.label   = label_reg;
                                res.address = to_out_addr(addr_reg);
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (hit_reg)
                            begin
                                res.status  = ST_FOUND;
                                res.index   = to_index(cmp_idx_reg);
                                res.label   = rd_label;
                                res.address = to_out_addr(rd_addr);
                            end
                            else
                            begin
                                res.status = ST_NOT_FOUND;
                            end
                        end
                        OP_MODIFY:
                        begin
                            if (hit_reg)
                            begin
                                // The stored label equals the request label, so the
                                // whole entry is rewritten in one go.
                                mem_wr_en   = 1'b1;
                                res.status  = ST_MODIFIED;
                                res.index   = to_index(cmp_idx_reg);
                                res.label   = label_reg;
                                res.address = to_out_addr(addr_reg);
                            end
                            else
                            begin
                                res.status = ST_NOT_FOUND;
                            end
                        end
                        OP_DUMP:
                        begin
                            res.status = ST_EMPTY;
                        end
                        default:
                        begin
                            res.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_idx_reg <= cmp_idx_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        label_reg <= label_next;
        addr_reg  <= addr_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("memory read and write in the same cycle");

    a_rd_written: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (rd_idx_reg < count_reg))
        else $error("read of an entry that was never written");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.last) |=> (state_reg == S_IDLE))
        else $error("final result did not return the sequencer to idle");
`endif

endmodule

// ===== rtl/symbol_table_engine.sv =====
// Symbol table engine: stores up to TABLE_DEPTH labels of 20 characters with an
// address each, and answers insert, search, modify and dump requests one at a
// time. Insert, search and modify read the entry memory one entry per cycle,
// stopping at a match or once every stored entry has been read. A dump sends
// one result per stored entry (at most 64) at up to one per cycle while the
// output is not stalled; a dump of an empty table gets one empty result. The
// memory needs no clearing after reset; only entries below the entry count are ever read.
// Depends on ste_pkg, ste_ctrl and ste_store.
module symbol_table_engine #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // label_chars_0_7, label_chars_8_15, label_chars_16_19, address_value
    input  logic [ste_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // entry_index, entry_chars_0_7, entry_chars_8_15, entry_chars_16_19,
    // entry_address, two zero bits
    output logic [ste_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    import ste_pkg::*;

    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = LABEL_W + ADDR_BITS;

    logic                 out_valid_reg;
    result_t              out_res_reg;
    logic                 out_free;
    logic                 res_load;
    result_t              res;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_idx;
    logic [ENTRY_W-1:0]   mem_rd_data;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_idx;
    logic [ENTRY_W-1:0]   mem_wr_data;

    // The output register frees its slot in the same cycle that a result is taken.
    assign out_free = !out_valid_reg || m_axis_tready;

    ste_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (op_t'(s_axis_tuser)),
        .in_data     (s_axis_tdata),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_idx  (mem_rd_idx),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_idx  (mem_wr_idx),
        .mem_wr_data (mem_wr_data)
    );

    ste_store #(
        .DEPTH  (TABLE_DEPTH),
        .IDX_W  (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {2'b00, out_res_reg.address, out_res_reg.label, out_res_reg.index};

endmodule
